>>> hw/rtl/arpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_pkg: shared types, constants and microprogram
// Fixed-point formats, register codes, control-word layout, the sequencer
// program and the saturating arithmetic helpers of the position controller.
// ----------------------------------------------------------------------------
package arpc_pkg;

    // Number formats
    localparam int DATA_W  = 48;             // signed data word
    localparam int FRAC_W  = 24;             // fraction bits of data and of dt
    localparam int DT_W    = 24;             // time step field, unsigned Q0.24
    localparam int GAIN_W  = 40;             // gain registers, unsigned
    localparam int MUL_LO  = DATA_W / 2;     // low slice of the multiplier operand
    localparam int MUL_HI  = DATA_W - MUL_LO;
    localparam int CNT_W   = $clog2(DATA_W);
    localparam int PC_W    = 5;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 64;
    localparam int CFG_LSB = 3;              // registers on 8-byte strides

    localparam logic [1:0] CFG_SLOPE_GAIN   = 2'd0;
    localparam logic [1:0] CFG_DIVISOR_GAIN = 2'd1;
    localparam logic [1:0] CFG_OFFSET_GAIN  = 2'd2;
    localparam logic [1:0] CFG_ROBUST_GAIN  = 2'd3;

    typedef logic signed [DATA_W-1:0] t_data;
    typedef logic        [GAIN_W-1:0] t_gain;

    localparam longint ONE = 64'sd1 <<< FRAC_W;

    localparam t_data DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam t_data DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // Reset values
    localparam t_data SLOPE_RST   = t_data'(-(808 * ONE) / 10);
    localparam t_data DIVISOR_RST = t_data'(20 * ONE);
    localparam t_data OFFSET_RST  = t_data'(20 * ONE);
    localparam t_gain SLOPE_GAIN_RST   = t_gain'(20 * ONE);
    localparam t_gain DIVISOR_GAIN_RST = t_gain'(ONE / 1000);
    localparam t_gain OFFSET_GAIN_RST  = t_gain'(200 * ONE);
    localparam t_gain ROBUST_GAIN_RST  = t_gain'(ONE);

    // Projection bounds
    localparam t_data LIM_HI_SLOPE   = t_data'(400 * ONE);
    localparam t_data LIM_HI_DIVISOR = t_data'(100 * ONE);
    localparam t_data LIM_HI_OFFSET  = t_data'(300 * ONE);
    localparam t_data LIM_LO_SLOPE   = t_data'(-150 * ONE);
    localparam t_data LIM_LO_DIVISOR = t_data'(-100 * ONE);
    localparam t_data LIM_LO_OFFSET  = t_data'(-3000 * ONE);

    localparam logic [1:0] PRJ_SLOPE   = 2'd0;
    localparam logic [1:0] PRJ_DIVISOR = 2'd1;
    localparam logic [1:0] PRJ_OFFSET  = 2'd2;

    // Register-file selects
    typedef enum logic [3:0] {
        R_Q, R_QR, R_DQR, R_DT,
        R_P0, R_P1, R_P2,
        R_G0, R_G1, R_G2, R_G3,
        R_E, R_T, R_UA, R_D
    } t_reg;

    // Micro operations
    typedef enum logic [2:0] {
        OP_END, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_JPRJ, OP_OUT
    } t_op;

    typedef struct packed {
        t_op             op;
        t_reg            dst;
        t_reg            a;
        t_reg            b;
        logic [1:0]      idx;
        logic [PC_W-1:0] tgt;
    } t_uword;

    // Multiply/divide unit handshake
    typedef struct packed {
        logic  start;
        logic  is_div;
        t_data a;
        t_data b;
    } t_mdu_req;

    typedef struct packed {
        logic  done;
        logic  zero;
        t_data result;
    } t_mdu_rsp;

    // Jump targets
    localparam logic [PC_W-1:0] L_DIVISOR = PC_W'(13);
    localparam logic [PC_W-1:0] L_OFFSET  = PC_W'(18);
    localparam logic [PC_W-1:0] L_DONE    = PC_W'(22);

    // Control store
    function automatic t_uword ucode(input logic [PC_W-1:0] pc);
        t_uword w;
        case (pc)
            PC_W'(0):  w = '{OP_SUB,  R_E,  R_Q,  R_QR,  PRJ_SLOPE,   '0};  // e
            PC_W'(1):  w = '{OP_MUL,  R_T,  R_P0, R_Q,   PRJ_SLOPE,   '0};
            PC_W'(2):  w = '{OP_ADD,  R_T,  R_T,  R_P2,  PRJ_SLOPE,   '0};
            PC_W'(3):  w = '{OP_SUB,  R_T,  R_T,  R_DQR, PRJ_SLOPE,   '0};  // num
            PC_W'(4):  w = '{OP_DIV,  R_UA, R_T,  R_P1,  PRJ_SLOPE,   '0};  // ua
            PC_W'(5):  w = '{OP_MUL,  R_T,  R_G3, R_E,   PRJ_SLOPE,   '0};
            PC_W'(6):  w = '{OP_ADD,  R_T,  R_UA, R_T,   PRJ_SLOPE,   '0};  // u
            PC_W'(7):  w = '{OP_OUT,  R_T,  R_T,  R_T,   PRJ_SLOPE,   '0};
            PC_W'(8):  w = '{OP_MUL,  R_D,  R_G0, R_Q,   PRJ_SLOPE,   '0};
            PC_W'(9):  w = '{OP_MUL,  R_D,  R_D,  R_E,   PRJ_SLOPE,   '0};
            PC_W'(10): w = '{OP_JPRJ, R_D,  R_P0, R_D,   PRJ_SLOPE,   L_DIVISOR};
            PC_W'(11): w = '{OP_MUL,  R_D,  R_D,  R_DT,  PRJ_SLOPE,   '0};
            PC_W'(12): w = '{OP_ADD,  R_P0, R_P0, R_D,   PRJ_SLOPE,   '0};
            PC_W'(13): w = '{OP_MUL,  R_D,  R_G1, R_UA,  PRJ_DIVISOR, '0};
            PC_W'(14): w = '{OP_MUL,  R_D,  R_D,  R_E,   PRJ_DIVISOR, '0};
            PC_W'(15): w = '{OP_JPRJ, R_D,  R_P1, R_D,   PRJ_DIVISOR, L_OFFSET};
            PC_W'(16): w = '{OP_MUL,  R_D,  R_D,  R_DT,  PRJ_DIVISOR, '0};
            PC_W'(17): w = '{OP_ADD,  R_P1, R_P1, R_D,   PRJ_DIVISOR, '0};
            PC_W'(18): w = '{OP_MUL,  R_D,  R_G2, R_E,   PRJ_OFFSET,  '0};
            PC_W'(19): w = '{OP_JPRJ, R_D,  R_P2, R_D,   PRJ_OFFSET,  L_DONE};
            PC_W'(20): w = '{OP_MUL,  R_D,  R_D,  R_DT,  PRJ_OFFSET,  '0};
            PC_W'(21): w = '{OP_ADD,  R_P2, R_P2, R_D,   PRJ_OFFSET,  '0};
            default:   w = '{OP_END,  R_T,  R_T,  R_T,   PRJ_SLOPE,   '0};
        endcase
        return w;
    endfunction

    // Saturating add or subtract
    function automatic t_data sat_addsub(input t_data a, input t_data b, input logic sub);
        logic signed [DATA_W:0] s;
        s = sub ? ({a[DATA_W-1], a} - {b[DATA_W-1], b})
                : ({a[DATA_W-1], a} + {b[DATA_W-1], b});
        if (s[DATA_W] != s[DATA_W-1]) begin
            return s[DATA_W] ? DATA_MIN : DATA_MAX;
        end
        return s[DATA_W-1:0];
    endfunction

    // True when the update would push the parameter further past its bound
    function automatic logic proj_blocked(input t_data p, input t_data d, input logic [1:0] idx);
        t_data hi;
        t_data lo;
        logic  d_pos;
        logic  d_neg;
        case (idx)
            PRJ_SLOPE:   begin hi = LIM_HI_SLOPE;   lo = LIM_LO_SLOPE;   end
            PRJ_DIVISOR: begin hi = LIM_HI_DIVISOR; lo = LIM_LO_DIVISOR; end
            PRJ_OFFSET:  begin hi = LIM_HI_OFFSET;  lo = LIM_LO_OFFSET;  end
            default:     begin hi = DATA_MAX;       lo = DATA_MIN;       end
        endcase
        d_neg = d[DATA_W-1];
        d_pos = !d[DATA_W-1] && (d != '0);
        return ((p >= hi) && d_pos) || ((p <= lo) && d_neg);
    endfunction

endpackage

>>> hw/rtl/arpc_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_in_if: sample input channel
// Valid/ready channel carrying one controller sample per transaction.
// ----------------------------------------------------------------------------
interface arpc_in_if import arpc_pkg::*; ();
    logic              valid;
    logic              ready;
    t_data             measured_angle;
    t_data             reference_angle;
    t_data             reference_velocity;
    logic [DT_W-1:0]   time_step;

    modport source (
        output valid, measured_angle, reference_angle, reference_velocity, time_step,
        input  ready
    );
    modport sink (
        input  valid, measured_angle, reference_angle, reference_velocity, time_step,
        output ready
    );
endinterface

>>> hw/rtl/arpc_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_out_if: drive output channel
// Valid/ready channel carrying one drive value and its zero-divisor flag.
// ----------------------------------------------------------------------------
interface arpc_out_if import arpc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_data drive_value;
    logic  divide_by_zero;

    modport source (
        output valid, drive_value, divide_by_zero,
        input  ready
    );
    modport sink (
        input  valid, drive_value, divide_by_zero,
        output ready
    );
endinterface

>>> hw/rtl/arpc_mdu.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arpc_mdu: multicycle fixed-point multiply/divide unit
// Sign-magnitude Q-format multiply in two half-width passes, and restoring
// division one quotient bit per cycle, both with saturation to DATA_W bits.
// ----------------------------------------------------------------------------
module arpc_mdu import arpc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mdu_req i_req,
    output t_mdu_rsp o_rsp
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_DIV  = 4'b0100,
        M_FIN  = 4'b1000
    } t_mstate;

    t_mstate                 r_state, n_state;
    logic [CNT_W-1:0]        r_cnt, n_cnt;
    logic                    r_done, n_done;
    logic                    r_neg, n_neg;
    logic                    r_is_div, n_is_div;
    logic                    r_over, n_over;
    logic                    r_zero, n_zero;
    logic                    r_nsign, n_nsign;
    logic [DATA_W-1:0]       r_ma, n_ma;
    logic [DATA_W-1:0]       r_mb, n_mb;
    logic [2*DATA_W-1:0]     r_acc, n_acc;
    logic [DATA_W-1:0]       r_rem, n_rem;
    logic [DATA_W-1:0]       r_dvd, n_dvd;
    logic [DATA_W-1:0]       r_quo, n_quo;
    t_data                   r_res, n_res;

    logic [DATA_W-1:0]        a_mag, b_mag;
    logic [MUL_HI-1:0]        mb_part;
    logic [DATA_W+MUL_HI-1:0] prod;
    logic [DATA_W:0]          rem_try;
    logic                     rem_ge;
    logic [2*DATA_W-FRAC_W-1:0] mag_c;
    logic [DATA_W-1:0]        lim;
    logic [DATA_W-1:0]        mag_f;
    logic                     sat;

    // Operand magnitudes at start
    assign a_mag = i_req.a[DATA_W-1] ? DATA_W'(-i_req.a) : DATA_W'(i_req.a);
    assign b_mag = i_req.b[DATA_W-1] ? DATA_W'(-i_req.b) : DATA_W'(i_req.b);

    // Shared multiplier: low slice first, then high slice
    assign mb_part = (r_cnt == '0) ? MUL_HI'(r_mb[MUL_LO-1:0]) : r_mb[DATA_W-1:MUL_LO];
    assign prod    = r_ma * mb_part;

    // Restoring division step
    assign rem_try = {r_rem, r_dvd[DATA_W-1]};
    assign rem_ge  = rem_try >= {1'b0, r_mb};

    // Final scaling and saturation
    assign mag_c = r_is_div ? {{(DATA_W-FRAC_W){1'b0}}, r_quo} : r_acc[2*DATA_W-1:FRAC_W];
    assign lim   = r_neg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    assign sat   = r_over || (mag_c > {{(DATA_W-FRAC_W){1'b0}}, lim});
    assign mag_f = sat ? lim : mag_c[DATA_W-1:0];

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_done   = 1'b0;
        n_neg    = r_neg;
        n_is_div = r_is_div;
        n_over   = r_over;
        n_zero   = r_zero;
        n_nsign  = r_nsign;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_dvd    = r_dvd;
        n_quo    = r_quo;
        n_res    = r_res;
        case (r_state)
            M_IDLE: begin
                if (i_req.start) begin
                    n_neg    = i_req.a[DATA_W-1] ^ i_req.b[DATA_W-1];
                    n_nsign  = i_req.a[DATA_W-1];
                    n_is_div = i_req.is_div;
                    n_ma     = a_mag;
                    n_mb     = b_mag;
                    n_cnt    = '0;
                    n_over   = 1'b0;
                    n_zero   = 1'b0;
                    n_quo    = '0;
                    if (!i_req.is_div) begin
                        n_state = M_MUL;
                    end else if (i_req.b == '0) begin
                        n_zero  = 1'b1;
                        n_state = M_FIN;
                    end else begin
                        // quotient would need more than DATA_W bits
                        n_over  = (a_mag >> (DATA_W - FRAC_W)) >= b_mag;
                        n_rem   = a_mag >> (DATA_W - FRAC_W);
                        n_dvd   = a_mag << FRAC_W;
                        n_state = n_over ? M_FIN : M_DIV;
                    end
                end
            end
            M_MUL: begin
                if (r_cnt == '0) begin
                    n_acc = {{(DATA_W-MUL_HI){1'b0}}, prod};
                    n_cnt = CNT_W'(1);
                end else begin
                    n_acc   = r_acc + {prod, {MUL_LO{1'b0}}};
                    n_state = M_FIN;
                end
            end
            M_DIV: begin
                n_rem = rem_ge ? DATA_W'(rem_try - {1'b0, r_mb}) : rem_try[DATA_W-1:0];
                n_quo = {r_quo[DATA_W-2:0], rem_ge};
                n_dvd = r_dvd << 1;
                if (r_cnt == CNT_W'(DATA_W - 1)) begin
                    n_state = M_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            M_FIN: begin
                if (r_zero) begin
                    n_res = r_nsign ? DATA_MIN : DATA_MAX;
                end else begin
                    n_res = r_neg ? t_data'(-mag_f) : t_data'(mag_f);
                end
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_cnt   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_neg    <= n_neg;
        r_is_div <= n_is_div;
        r_over   <= n_over;
        r_zero   <= n_zero;
        r_nsign  <= n_nsign;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_dvd    <= n_dvd;
        r_quo    <= n_quo;
        r_res    <= n_res;
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.zero   = r_zero;
    assign o_rsp.result = r_res;

endmodule

>>> hw/rtl/adaptive_robust_position_controller.sv
`timescale 1ns / 1ps
// Samples are accepted only while the sequencer is idle, so a new sample waits
// until the program for the last one has formed its drive value and updated
// the parameters. The 48-step restoring divider and the ten multiplies of the
// shared unit set the run time; projection that holds a parameter skips its
// update steps, and a zero divisor or an overflowing quotient skips the divide
// steps. Reset (synchronous, active low) loads default gains and parameters.
// ----------------------------------------------------------------------------
// adaptive_robust_position_controller: microcoded adaptive robust controller
// A control-store program sequences one multiply/divide unit and a saturating
// adder over a small register file to form the drive and update parameters.
// ----------------------------------------------------------------------------
module adaptive_robust_position_controller import arpc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    arpc_in_if.sink            i_in,
    arpc_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_WAIT = 3'b100
    } t_seq;

    t_seq            r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    logic            r_out_valid, n_out_valid;

    // Register file
    t_data r_q, r_qr, r_dqr, r_dt;
    t_data r_p0, r_p1, r_p2;
    t_data r_e, r_t, r_ua, r_d;
    t_gain r_slope_gain, r_divisor_gain, r_offset_gain, r_robust_gain;
    logic  r_zero;
    t_data r_out_drive;
    logic  r_out_dbz;

    t_uword   w;
    t_data    opa, opb;
    logic     wr_en;
    t_data    wr_val;
    logic     out_load;
    logic     in_take;
    logic     cfg_wr;
    logic [1:0] cfg_idx;
    t_mdu_req mdu_req;
    t_mdu_rsp mdu_rsp;

    function automatic t_data rd_sel(input t_reg s);
        case (s)
            R_Q:     return r_q;
            R_QR:    return r_qr;
            R_DQR:   return r_dqr;
            R_DT:    return r_dt;
            R_P0:    return r_p0;
            R_P1:    return r_p1;
            R_P2:    return r_p2;
            R_G0:    return {{(DATA_W-GAIN_W){1'b0}}, r_slope_gain};
            R_G1:    return {{(DATA_W-GAIN_W){1'b0}}, r_divisor_gain};
            R_G2:    return {{(DATA_W-GAIN_W){1'b0}}, r_offset_gain};
            R_G3:    return {{(DATA_W-GAIN_W){1'b0}}, r_robust_gain};
            R_E:     return r_e;
            R_T:     return r_t;
            R_UA:    return r_ua;
            R_D:     return r_d;
            default: return '0;
        endcase
    endfunction

    assign w   = ucode(r_pc);
    assign opa = rd_sel(w.a);
    assign opb = rd_sel(w.b);

    assign in_take  = i_in.valid && i_in.ready;
    assign out_load = (r_state == S_RUN) && (w.op == OP_OUT) && (!r_out_valid || o_out.ready);

    // Sequencer
    always_comb begin
        n_state        = r_state;
        n_pc           = r_pc;
        wr_en          = 1'b0;
        wr_val         = sat_addsub(opa, opb, w.op == OP_SUB);
        mdu_req.start  = 1'b0;
        mdu_req.is_div = (w.op == OP_DIV);
        mdu_req.a      = opa;
        mdu_req.b      = opb;
        case (r_state)
            S_IDLE: begin
                if (in_take) begin
                    n_pc    = '0;
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                case (w.op)
                    OP_ADD, OP_SUB: begin
                        wr_en = 1'b1;
                        n_pc  = r_pc + 1'b1;
                    end
                    OP_MUL, OP_DIV: begin
                        mdu_req.start = 1'b1;
                        n_state       = S_WAIT;
                    end
                    OP_JPRJ: begin
                        n_pc = proj_blocked(opa, opb, w.idx) ? w.tgt : r_pc + 1'b1;
                    end
                    OP_OUT: begin
                        if (out_load) begin
                            n_pc = r_pc + 1'b1;
                        end
                    end
                    OP_END: begin
                        n_state = S_IDLE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_WAIT: begin
                wr_val = mdu_rsp.result;
                if (mdu_rsp.done) begin
                    wr_en   = 1'b1;
                    n_pc    = r_pc + 1'b1;
                    n_state = S_RUN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Output slot
    assign n_out_valid = (r_out_valid && !o_out.ready) || out_load;

    // Configuration decode
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[CFG_LSB+1:CFG_LSB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pc           <= '0;
            r_out_valid    <= 1'b0;
            r_p0           <= SLOPE_RST;
            r_p1           <= DIVISOR_RST;
            r_p2           <= OFFSET_RST;
            r_slope_gain   <= SLOPE_GAIN_RST;
            r_divisor_gain <= DIVISOR_GAIN_RST;
            r_offset_gain  <= OFFSET_GAIN_RST;
            r_robust_gain  <= ROBUST_GAIN_RST;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_out_valid <= n_out_valid;
            if (cfg_wr) begin
                case (cfg_idx)
                    CFG_SLOPE_GAIN:   r_slope_gain   <= pwdata[GAIN_W-1:0];
                    CFG_DIVISOR_GAIN: r_divisor_gain <= pwdata[GAIN_W-1:0];
                    CFG_OFFSET_GAIN:  r_offset_gain  <= pwdata[GAIN_W-1:0];
                    CFG_ROBUST_GAIN:  r_robust_gain  <= pwdata[GAIN_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (wr_en) begin
                case (w.dst)
                    R_P0:    r_p0 <= wr_val;
                    R_P1:    r_p1 <= wr_val;
                    R_P2:    r_p2 <= wr_val;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers and sample latch
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_q   <= i_in.measured_angle;
            r_qr  <= i_in.reference_angle;
            r_dqr <= i_in.reference_velocity;
            r_dt  <= {{(DATA_W-DT_W){1'b0}}, i_in.time_step};
        end
        if (wr_en) begin
            case (w.dst)
                R_E:     r_e  <= wr_val;
                R_T:     r_t  <= wr_val;
                R_UA:    r_ua <= wr_val;
                R_D:     r_d  <= wr_val;
                default: begin
                end
            endcase
        end
        if (wr_en && (w.op == OP_DIV)) begin
            r_zero <= mdu_rsp.zero;
        end
        if (out_load) begin
            r_out_drive <= opa;
            r_out_dbz   <= r_zero;
        end
    end

    // Config readback
    always_comb begin
        case (cfg_idx)
            CFG_SLOPE_GAIN:   prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_slope_gain};
            CFG_DIVISOR_GAIN: prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_divisor_gain};
            CFG_OFFSET_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_offset_gain};
            CFG_ROBUST_GAIN:  prdata = {{(PDATA_W-GAIN_W){1'b0}}, r_robust_gain};
            default:          prdata = '0;
        endcase
    end
    assign pready = 1'b1;

    arpc_mdu u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mdu_req),
        .o_rsp   (mdu_rsp)
    );

    assign i_in.ready           = (r_state == S_IDLE);
    assign o_out.valid          = r_out_valid;
    assign o_out.drive_value    = r_out_drive;
    assign o_out.divide_by_zero = r_out_dbz;

    // Unit results only arrive while the sequencer waits for them
    a_rsp_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_rsp.done |-> (r_state == S_WAIT))
        else $error("mdu result outside wait state");

    // An accepted sample starts the program at its first step
    a_start_prog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_take |=> ((r_state == S_RUN) && (r_pc == '0)))
        else $error("program did not start at step zero");

    // Issuing a unit operation parks the sequencer
    a_issue_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mdu_req.start |=> (r_state == S_WAIT))
        else $error("sequencer did not wait on unit");

endmodule
